>>> hdl/dpa_pkg.sv
// Shared types and constants for the delta patch applier.
`default_nettype none

package dpa_pkg;

  // Default depth of the old-buffer store, in bytes
  localparam int unsigned OLD_DEPTH_DEF = 65536;
  // Largest new-buffer length that writes may reach
  localparam int unsigned TARGET_DEPTH  = 65536;

  localparam int unsigned TSIZE_W = 17;

  // Input commands
  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_PATCH = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;

  // Record kinds
  localparam logic [1:0] KIND_COPY   = 2'd0;
  localparam logic [1:0] KIND_INSERT = 2'd1;
  localparam logic [1:0] KIND_REPEAT = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_TYPE = 2'd1;
  localparam logic [1:0] ST_BUSY     = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  // Record type bytes
  localparam logic [7:0] CHAR_COPY   = 8'h43;
  localparam logic [7:0] CHAR_INSERT = 8'h49;
  localparam logic [7:0] CHAR_REPEAT = 8'h52;

  // One result; from_mem selects the store read data as the written byte
  typedef struct packed {
    logic        write_valid;
    logic [15:0] write_addr;
    logic [7:0]  write_data;
    logic        from_mem;
    logic        run_pending;
    logic [1:0]  status;
  } dpa_result_t;

endpackage

`default_nettype wire

>>> hdl/delta_patch_applier.sv
// Top level of the delta patch applier: parser, old-byte store and result pipeline.
`default_nettype none

// Applies a copy / insert / repeat patch to an old buffer. Load the old buffer
// first with command 0 transactions, then feed the decompressed patch stream
// with command 1 and advance copy or repeat runs with command 2 ticks; every
// input transaction yields exactly one result transaction. The block takes one
// transaction per cycle unless stalled; each result passes the read stage,
// covering the registered old-store read that copy runs use, then the output
// register. A two-deep result pipeline (read stage plus output register)
// keeps the input open while one finished result waits on a stalled output.
// Program target_size through the cfg port only while the block is idle;
// cfg_ready is always high. The old store has no reset and needs no clearing
// pass: entries are read only below the count of bytes already loaded.
module delta_patch_applier #(
  parameter  int unsigned OLD_DEPTH = dpa_pkg::OLD_DEPTH_DEF,
  localparam int unsigned OLD_AW    = $clog2(OLD_DEPTH)
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [dpa_pkg::TSIZE_W-1:0] cfg_target_size,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [1:0]                  in_command,
  input  wire logic [7:0]                  in_data_byte,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic                             out_write_valid,
  output logic [15:0]                      out_write_addr,
  output logic [7:0]                       out_write_data,
  output logic                             out_run_pending,
  output logic [1:0]                       out_status
);

  import dpa_pkg::*;

  logic [TSIZE_W-1:0] target_size_r;

  logic               accept;
  dpa_result_t        step_res;
  logic               wr_en;
  logic [OLD_AW-1:0]  wr_addr;
  logic [7:0]         wr_data;
  logic               rd_en;
  logic [OLD_AW-1:0]  rd_addr;
  logic [7:0]         rd_data;

  // Read stage: result waiting for the store read data
  logic               p_valid_r;
  dpa_result_t        p_res_r;
  logic               p_move;
  logic [7:0]         p_data;

  // Output register
  logic               o_valid_r;
  logic               o_wvalid_r;
  logic [15:0]        o_addr_r;
  logic [7:0]         o_data_r;
  logic               o_pending_r;
  logic [1:0]         o_status_r;

  // Configuration: single register, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_size_r <= '0;
    end else if (cfg_valid) begin
      target_size_r <= cfg_target_size;
    end
  end

  // The read stage advances whenever the output register is free or drains
  assign p_move   = p_valid_r && !(o_valid_r && out_stall);
  assign in_stall = p_valid_r && o_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  dpa_parser #(
    .OLD_DEPTH (OLD_DEPTH)
  ) u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .command     (in_command),
    .data_byte   (in_data_byte),
    .target_size (target_size_r),
    .result      (step_res),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data),
    .rd_en       (rd_en),
    .rd_addr     (rd_addr)
  );

  // A load and a copy read never come from the same transaction, and a byte
  // written at one edge is visible to a read issued at the next, so no
  // forwarding is needed around the store.
  dpa_old_store #(
    .DEPTH (OLD_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Store read data stays put while the read stage holds: no new read is
  // issued until the stage frees up.
  assign p_data = p_res_r.from_mem ? rd_data : p_res_r.write_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
    end else begin
      p_valid_r <= accept || (p_valid_r && !p_move);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p_res_r <= step_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_valid_r <= 1'b0;
    end else begin
      o_valid_r <= p_move || (o_valid_r && out_stall);
    end
  end

  // Load the output register as the read stage hands over; hold otherwise
  always_ff @(posedge clk) begin
    if (p_move) begin
      o_wvalid_r  <= p_res_r.write_valid;
      o_addr_r    <= p_res_r.write_addr;
      o_data_r    <= p_data;
      o_pending_r <= p_res_r.run_pending;
      o_status_r  <= p_res_r.status;
    end
  end

  assign out_valid       = o_valid_r;
  assign out_write_valid = o_wvalid_r;
  assign out_write_addr  = o_addr_r;
  assign out_write_data  = o_data_r;
  assign out_run_pending = o_pending_r;
  assign out_status      = o_status_r;

endmodule

`default_nettype wire

>>> hdl/dpa_old_store.sv
// Old-buffer byte store: one write port, one registered read port.
`default_nettype none

module dpa_old_store #(
  parameter  int unsigned DEPTH = 65536,
  localparam int unsigned AW    = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [7:0]    wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic [7:0]         rd_data
);

  logic [7:0] mem_r [DEPTH];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Hold read data until the next read so a stalled result keeps its byte
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

>>> hdl/dpa_parser.sv
// Patch record parser and run sequencer; owns the old-byte fill count.
`default_nettype none

module dpa_parser #(
  parameter  int unsigned OLD_DEPTH = 65536,
  localparam int unsigned OLD_AW    = $clog2(OLD_DEPTH)
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       accept,
  input  wire logic [1:0]                 command,
  input  wire logic [7:0]                 data_byte,
  input  wire logic [dpa_pkg::TSIZE_W-1:0] target_size,
  output dpa_pkg::dpa_result_t            result,
  output logic                            wr_en,
  output logic [OLD_AW-1:0]               wr_addr,
  output logic [7:0]                      wr_data,
  output logic                            rd_en,
  output logic [OLD_AW-1:0]               rd_addr
);

  import dpa_pkg::*;

  localparam int unsigned OLD_CW = $clog2(OLD_DEPTH + 1);

  localparam logic [2:0] PH_TYPE   = 3'd0;
  localparam logic [2:0] PH_INDEX  = 3'd1;
  localparam logic [2:0] PH_SECOND = 3'd2;
  localparam logic [2:0] PH_THIRD  = 3'd3;
  localparam logic [2:0] PH_VALUE  = 3'd4;
  localparam logic [2:0] PH_DATA   = 3'd5;
  localparam logic [2:0] PH_RUN    = 3'd6;

  localparam logic [2:0] FIELD_LAST = 3'd7;

  logic [2:0]        phase_r, phase_nxt;
  logic [1:0]        kind_r, kind_nxt;
  logic [2:0]        fbc_r, fbc_nxt;
  logic [63:0]       fasm_r, fasm_nxt;
  logic [63:0]       dest_r, dest_nxt;
  logic [63:0]       src_r, src_nxt;
  logic [63:0]       limit_r, limit_nxt;
  logic [7:0]        fill_r, fill_nxt;
  logic [OLD_CW-1:0] old_count_r, old_count_nxt;

  logic [63:0] tlim;
  logic [63:0] field_val;
  logic        emit_now;
  logic        load_ok;
  dpa_result_t res;

  // Writes stop at the smaller of the programmed length and the target depth
  assign tlim = (64'(target_size) < 64'(TARGET_DEPTH)) ? 64'(target_size)
                                                      : 64'(TARGET_DEPTH);

  function automatic logic can_emit(input logic [63:0] dest, input logic [63:0] src,
                                    input logic [63:0] lim, input logic [1:0] kind,
                                    input logic [63:0] cnt, input logic [63:0] tl);
    logic ok;
    if (dest >= tl) begin
      ok = 1'b0;
    end else if (kind == KIND_COPY) begin
      ok = (src < lim) && (src < cnt);
    end else begin
      ok = (lim != 64'd0);
    end
    return ok;
  endfunction

  assign field_val = fasm_r | (64'(data_byte) << {fbc_r, 3'b000});
  assign emit_now  = can_emit(dest_r, src_r, limit_r, kind_r, 64'(old_count_r), tlim);
  assign load_ok   = (old_count_r < OLD_CW'(OLD_DEPTH));

  always_comb begin
    phase_nxt     = phase_r;
    kind_nxt      = kind_r;
    fbc_nxt       = fbc_r;
    fasm_nxt      = fasm_r;
    dest_nxt      = dest_r;
    src_nxt       = src_r;
    limit_nxt     = limit_r;
    fill_nxt      = fill_r;
    old_count_nxt = old_count_r;
    res           = '0;
    wr_en         = 1'b0;
    rd_en         = 1'b0;

    unique case (command)
      CMD_LOAD: begin
        if (load_ok) begin
          wr_en         = 1'b1;
          old_count_nxt = old_count_r + OLD_CW'(1);
        end else begin
          res.status = ST_FULL;
        end
      end
      CMD_PATCH: begin
        unique case (phase_r) inside
          PH_RUN: begin
            res.status = ST_BUSY;
          end
          PH_TYPE: begin
            if (data_byte == CHAR_COPY || data_byte == CHAR_INSERT ||
                data_byte == CHAR_REPEAT) begin
              kind_nxt  = (data_byte == CHAR_COPY)   ? KIND_COPY :
                          (data_byte == CHAR_INSERT) ? KIND_INSERT : KIND_REPEAT;
              fbc_nxt   = '0;
              fasm_nxt  = '0;
              phase_nxt = PH_INDEX;
            end else begin
              res.status = ST_BAD_TYPE;
            end
          end
          PH_VALUE: begin
            fill_nxt  = data_byte;
            phase_nxt = emit_now ? PH_RUN : PH_TYPE;
          end
          PH_DATA: begin
            if (dest_r < tlim) begin
              res.write_valid = 1'b1;
              res.write_addr  = dest_r[15:0];
              res.write_data  = data_byte;
            end
            dest_nxt  = dest_r + 64'd1;
            limit_nxt = limit_r - 64'd1;
            if (limit_r == 64'd1) begin
              phase_nxt = PH_TYPE;
            end
          end
          PH_INDEX, PH_SECOND, PH_THIRD: begin
            if (fbc_r == FIELD_LAST) begin
              fbc_nxt  = '0;
              fasm_nxt = '0;
              unique case (phase_r)
                PH_INDEX: begin
                  dest_nxt  = field_val;
                  phase_nxt = PH_SECOND;
                end
                PH_SECOND: begin
                  if (kind_r == KIND_COPY) begin
                    src_nxt   = field_val;
                    phase_nxt = PH_THIRD;
                  end else if (kind_r == KIND_INSERT) begin
                    limit_nxt = field_val;
                    phase_nxt = (field_val != 64'd0) ? PH_DATA : PH_TYPE;
                  end else begin
                    limit_nxt = field_val;
                    phase_nxt = PH_VALUE;
                  end
                end
                default: begin
                  limit_nxt = field_val;
                  phase_nxt = can_emit(dest_r, src_r, field_val, kind_r,
                                       64'(old_count_r), tlim) ? PH_RUN : PH_TYPE;
                end
              endcase
            end else begin
              fbc_nxt  = fbc_r + 3'd1;
              fasm_nxt = field_val;
            end
          end
          default: begin
          end
        endcase
      end
      CMD_TICK: begin
        if (phase_r == PH_RUN) begin
          if (emit_now) begin
            res.write_valid = 1'b1;
            res.write_addr  = dest_r[15:0];
            if (kind_r == KIND_COPY) begin
              rd_en        = 1'b1;
              res.from_mem = 1'b1;
              src_nxt      = src_r + 64'd1;
            end else begin
              res.write_data = fill_r;
              limit_nxt      = limit_r - 64'd1;
            end
            dest_nxt = dest_r + 64'd1;
          end
          phase_nxt = can_emit(dest_nxt, src_nxt, limit_nxt, kind_r,
                               64'(old_count_r), tlim) ? PH_RUN : PH_TYPE;
        end
      end
      default: begin
      end
    endcase

    res.run_pending = (phase_nxt == PH_RUN);
    wr_en = wr_en & accept;
    rd_en = rd_en & accept;
  end

  assign result  = res;
  assign wr_addr = old_count_r[OLD_AW-1:0];
  assign wr_data = data_byte;
  assign rd_addr = src_r[OLD_AW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_TYPE;
      kind_r      <= KIND_COPY;
      fbc_r       <= '0;
      fasm_r      <= '0;
      dest_r      <= '0;
      src_r       <= '0;
      limit_r     <= '0;
      fill_r      <= '0;
      old_count_r <= '0;
    end else if (accept) begin
      phase_r     <= phase_nxt;
      kind_r      <= kind_nxt;
      fbc_r       <= fbc_nxt;
      fasm_r      <= fasm_nxt;
      dest_r      <= dest_nxt;
      src_r       <= src_nxt;
      limit_r     <= limit_nxt;
      fill_r      <= fill_nxt;
      old_count_r <= old_count_nxt;
    end
  end

endmodule

`default_nettype wire

>>> hdl/dpa_checker.sv
// Port-level checks for the delta patch applier, bound to the top level.
`default_nettype none

module dpa_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic        out_write_valid,
  input wire logic [15:0] out_write_addr,
  input wire logic [7:0]  out_write_data,
  input wire logic        out_run_pending,
  input wire logic [1:0]  out_status
);

  import dpa_pkg::*;

  // A result that flags a problem never writes the new buffer
  a_err_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> !out_write_valid)
    else $error("write on an error result");

  // Results without a write carry zero address and data
  a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_write_valid |-> out_write_addr == 16'd0 && out_write_data == 8'd0)
    else $error("stale address or data on a result without write");

  // A busy status comes only during a run, and that run goes on
  a_busy_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_BUSY |-> out_run_pending)
    else $error("busy status outside a run");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_write_valid) &&
      $stable(out_write_addr) && $stable(out_write_data) &&
      $stable(out_run_pending) && $stable(out_status))
    else $error("stalled result changed");

  // No result straight out of reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind delta_patch_applier dpa_checker u_dpa_checker (.*);

`default_nettype wire
